// ===== hw/rtl/wscp_pkg.sv =====
package wscp_pkg;

    localparam int STORE_BYTES_DEF = 16384;
    localparam int MAX_SIDE_DEF    = 125;

    localparam int ADDR_W  = 14;
    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 7;
    localparam int MAG_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_PLOT = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] OUT_PLACED    = 2'd0;
    localparam logic [1:0] OUT_COLLISION = 2'd1;
    localparam logic [1:0] OUT_UNCHANGED = 2'd2;
    localparam logic [1:0] OUT_ACCESS    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLISION   = 2'd2;

    localparam logic [SIZE_W-1:0] PLAY_WIDTH_RST  = 7'd60;
    localparam logic [SIZE_W-1:0] PLAY_HEIGHT_RST = 7'd20;
    localparam logic [BYTE_W-1:0] COLLISION_RST   = 8'd35;

    localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'd32;

    localparam logic [1:0] REM_X = 2'd0;
    localparam logic [1:0] REM_Y = 2'd1;
    localparam logic [1:0] REM_S = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] cell_addr;
        logic [BYTE_W-1:0] load_byte;
        logic [6:0]        anchor_x;
        logic [6:0]        anchor_y;
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        logic [BYTE_W-1:0] glyph;
        logic              last_element;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [ADDR_W-1:0] target_addr;
        logic [1:0]        outcome;
    } t_out;

    typedef struct packed {
        logic       take_item;
        logic       rem_start;
        logic [1:0] rem_sel;
        logic       lat_x;
        logic       lat_y;
        logic       mul;
        logic       sum;
        logic       lat_red;
        logic       mem_rd;
        logic       rmw;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_plot;
        logic rem_busy;
        logic rem_done;
        logic need_red;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/wscp_rem.sv =====
module wscp_rem #(
    parameter int DW  = 14,
    parameter int DVW = 15,
    parameter int CW  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [CW-1:0]  i_steps,
    input  logic [DW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output logic [DVW-1:0] o_rem
);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [DW-1:0]  r_dd;
    logic [DVW-1:0] r_div;
    logic [DVW-1:0] r_part;
    logic [DVW:0]   w_trial;
    logic [DVW:0]   w_diff;
    logic           w_ge;

    assign w_trial = {r_part, r_dd[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dd   <= i_dividend;
            r_div  <= i_divisor;
            r_part <= '0;
        end else if (r_busy) begin
            r_dd   <= {r_dd[DW-2:0], 1'b0};
            r_part <= w_ge ? w_diff[DVW-1:0] : w_trial[DVW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_part;

endmodule

// ===== hw/rtl/wscp_dp.sv =====
module wscp_dp #(
    parameter int STORE_BYTES = wscp_pkg::STORE_BYTES_DEF,
    parameter int MAX_SIDE    = wscp_pkg::MAX_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wscp_pkg::t_in                     i_item,
    input  logic                              i_cfg_we,
    input  logic [wscp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wscp_pkg::BYTE_W-1:0]       i_cfg_data,
    input  wscp_pkg::t_cmd                    i_cmd,
    output wscp_pkg::t_sts                    o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output wscp_pkg::t_out                    o_out_item
);

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int W3_W     = $clog2(MAX_SIDE + 4);
    localparam int PLOT_MAX = MAX_SIDE * (MAX_SIDE + 3) + MAX_SIDE;
    localparam int PAW      = $clog2(PLOT_MAX + 1);
    localparam int DW       = (PAW > wscp_pkg::ADDR_W) ? PAW : wscp_pkg::ADDR_W;
    localparam int DIV_MAX  = (STORE_BYTES > MAX_SIDE) ? STORE_BYTES : MAX_SIDE;
    localparam int DVW      = $clog2(DIV_MAX + 1);
    localparam int CW       = $clog2(DW + 1);
    localparam int SAW      = $clog2(STORE_BYTES);
    localparam int BW       = wscp_pkg::BYTE_W;

    logic [wscp_pkg::SIZE_W-1:0] r_play_width;
    logic [wscp_pkg::SIZE_W-1:0] r_play_height;
    logic [BW-1:0]               r_collision;

    wscp_pkg::t_in    r_item;
    logic             r_neg_x;
    logic             r_neg_y;
    logic [MAG_W_L-1:0] r_mag_x;
    logic [MAG_W_L-1:0] r_mag_y;
    localparam int MAG_W_L = wscp_pkg::MAG_W;

    logic [SIDE_W-1:0] r_mx;
    logic [SIDE_W-1:0] r_my;
    logic [DW-1:0]     r_prod;
    logic [DW-1:0]     r_addr;
    logic [BW-1:0]     r_q;
    wscp_pkg::t_out    r_res;
    logic              r_out_valid;
    wscp_pkg::t_out    r_out;

    logic [BW-1:0] r_mem [STORE_BYTES];

    logic signed [9:0] w_sx;
    logic signed [9:0] w_sy;
    logic [9:0]        w_nx;
    logic [9:0]        w_ny;
    logic [SIDE_W-1:0] w_w;
    logic [SIDE_W-1:0] w_h;
    logic [W3_W-1:0]   w_w3;
    logic [SIDE_W-1:0] w_row;
    logic [SIDE_W-1:0] w_r;
    logic [SIDE_W-1:0] w_wrap;
    logic [DW-1:0]     w_dividend;
    logic [DVW-1:0]    w_divisor;
    logic [CW-1:0]     w_steps;
    logic [DVW-1:0]    w_rem;
    logic              w_rem_busy;
    logic              w_rem_done;
    logic [SAW-1:0]    w_maddr;
    logic              w_we;
    logic [BW-1:0]     w_wdata;
    wscp_pkg::t_out    w_res;

    // size clamping
    always_comb begin
        if (r_play_width == '0) begin
            w_w = SIDE_W'(1);
        end else if (int'(r_play_width) > MAX_SIDE) begin
            w_w = SIDE_W'(MAX_SIDE);
        end else begin
            w_w = SIDE_W'(r_play_width);
        end
        if (r_play_height == '0) begin
            w_h = SIDE_W'(1);
        end else if (int'(r_play_height) > MAX_SIDE) begin
            w_h = SIDE_W'(MAX_SIDE);
        end else begin
            w_h = SIDE_W'(r_play_height);
        end
    end

    assign w_w3  = W3_W'(w_w) + W3_W'(3);
    assign w_row = w_h - r_my;

    assign w_sx = $signed({3'b000, i_item.anchor_x}) + {{2{i_item.offset_x[7]}}, i_item.offset_x};
    assign w_sy = $signed({3'b000, i_item.anchor_y}) + {{2{i_item.offset_y[7]}}, i_item.offset_y};
    assign w_nx = 10'd0 - w_sx;
    assign w_ny = 10'd0 - w_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_width  <= wscp_pkg::PLAY_WIDTH_RST;
            r_play_height <= wscp_pkg::PLAY_HEIGHT_RST;
            r_collision   <= wscp_pkg::COLLISION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wscp_pkg::CFG_PLAY_WIDTH: begin
                    r_play_width <= i_cfg_data[wscp_pkg::SIZE_W-1:0];
                end
                wscp_pkg::CFG_PLAY_HEIGHT: begin
                    r_play_height <= i_cfg_data[wscp_pkg::SIZE_W-1:0];
                end
                wscp_pkg::CFG_COLLISION: begin
                    r_collision <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // shared remainder unit
    always_comb begin
        case (i_cmd.rem_sel)
            wscp_pkg::REM_X: begin
                w_dividend = {r_mag_x, {(DW - MAG_W_L){1'b0}}};
                w_divisor  = DVW'(w_w);
                w_steps    = CW'(MAG_W_L);
            end
            wscp_pkg::REM_Y: begin
                w_dividend = {r_mag_y, {(DW - MAG_W_L){1'b0}}};
                w_divisor  = DVW'(w_h);
                w_steps    = CW'(MAG_W_L);
            end
            default: begin
                w_dividend = r_addr;
                w_divisor  = DVW'(STORE_BYTES);
                w_steps    = CW'(DW);
            end
        endcase
    end

    wscp_rem #(
        .DW  (DW),
        .DVW (DVW),
        .CW  (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rem_start),
        .i_steps    (w_steps),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_rem_busy),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // non-negative wrap of a remainder taken on the magnitude
    always_comb begin
        w_r = SIDE_W'(w_rem);
        if (i_cmd.lat_x) begin
            w_wrap = (r_neg_x && (w_r != '0)) ? (w_w - w_r) : w_r;
        end else begin
            w_wrap = (r_neg_y && (w_r != '0)) ? (w_h - w_r) : w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item  <= i_item;
            r_neg_x <= w_sx[9];
            r_neg_y <= w_sy[9];
            r_mag_x <= w_sx[9] ? w_nx[MAG_W_L-1:0] : w_sx[MAG_W_L-1:0];
            r_mag_y <= w_sy[9] ? w_ny[MAG_W_L-1:0] : w_sy[MAG_W_L-1:0];
            r_addr  <= DW'(i_item.cell_addr);
        end
        if (i_cmd.lat_x) begin
            r_mx <= w_wrap;
        end
        if (i_cmd.lat_y) begin
            r_my <= w_wrap;
        end
        if (i_cmd.mul) begin
            r_prod <= DW'(w_row * w_w3);
        end
        if (i_cmd.sum) begin
            r_addr <= r_prod + DW'(r_mx) + DW'(1);
        end
        if (i_cmd.lat_red) begin
            r_addr <= DW'(w_rem);
        end
        if (i_cmd.rmw) begin
            r_res <= w_res;
        end
    end

    // frame store
    assign w_maddr = SAW'(r_addr);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_maddr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_q <= r_mem[w_maddr];
        end
    end

    // cell update
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_item.load_byte;
        w_res.target_addr = wscp_pkg::ADDR_W'(r_addr);
        w_res.read_byte   = r_q;
        w_res.outcome     = wscp_pkg::OUT_ACCESS;
        case (r_item.mode)
            wscp_pkg::MODE_LOAD: begin
                w_we = i_cmd.rmw;
                w_res.read_byte = '0;
            end
            wscp_pkg::MODE_PLOT: begin
                if (r_q == wscp_pkg::BLANK_CHAR) begin
                    w_we    = i_cmd.rmw;
                    w_wdata = r_item.glyph;
                    w_res.read_byte = r_item.glyph;
                    w_res.outcome   = wscp_pkg::OUT_PLACED;
                end else if (r_item.glyph != wscp_pkg::BLANK_CHAR) begin
                    w_we    = i_cmd.rmw;
                    w_wdata = r_collision;
                    w_res.read_byte = r_collision;
                    w_res.outcome   = wscp_pkg::OUT_COLLISION;
                end else begin
                    w_res.outcome = wscp_pkg::OUT_UNCHANGED;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_sts.is_plot  = (r_item.mode == wscp_pkg::MODE_PLOT);
    assign o_sts.rem_busy = w_rem_busy;
    assign o_sts.rem_done = w_rem_done;
    assign o_sts.need_red = (32'(r_addr) >= 32'(STORE_BYTES));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule

// ===== hw/rtl/wscp_ctrl.sv =====
module wscp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wscp_pkg::t_sts i_sts,
    output wscp_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_XRUN = 4'd2;
    localparam logic [3:0] S_YRUN = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_SRUN = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_RMW  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_plot) begin
                    o_cmd.rem_start = 1'b1;
                    o_cmd.rem_sel   = wscp_pkg::REM_X;
                    n_state = S_XRUN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_XRUN: begin
                o_cmd.rem_sel = wscp_pkg::REM_X;
                if (i_sts.rem_done) begin
                    o_cmd.lat_x     = 1'b1;
                    o_cmd.rem_start = 1'b1;
                    o_cmd.rem_sel   = wscp_pkg::REM_Y;
                    n_state = S_YRUN;
                end
            end
            S_YRUN: begin
                o_cmd.rem_sel = wscp_pkg::REM_Y;
                if (i_sts.rem_done) begin
                    o_cmd.lat_y = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.rem_sel = wscp_pkg::REM_S;
                if (i_sts.need_red) begin
                    o_cmd.rem_start = 1'b1;
                    n_state = S_SRUN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SRUN: begin
                o_cmd.rem_sel = wscp_pkg::REM_S;
                if (i_sts.rem_done) begin
                    o_cmd.lat_red = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_RMW;
            end
            S_RMW: begin
                o_cmd.rmw = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/wrapped_sprite_cell_plotter.sv =====
// one item at a time; a plot item passes twice through the shared bit-serial remainder
// unit (8 steps for each of the column and row wraps) before its result is formed
// load and read items skip the wraps; an address at or beyond the store size adds one
// remainder pass; the result waits in an output register
// synchronous active-low reset clears the sequencer, the output valid and the size and
// collision registers (60, 20, 35); the frame store is not cleared
module wrapped_sprite_cell_plotter #(
    parameter int STORE_BYTES = wscp_pkg::STORE_BYTES_DEF,
    parameter int MAX_SIDE    = wscp_pkg::MAX_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  wscp_pkg::t_in                  i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output wscp_pkg::t_out                 o_out_item,
    input  logic                           i_cfg_we,
    input  logic [wscp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wscp_pkg::BYTE_W-1:0]    i_cfg_data
);

    wscp_pkg::t_cmd w_cmd;
    wscp_pkg::t_sts w_sts;

    wscp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wscp_dp #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_SIDE    (MAX_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item taken");

    a_rem_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rem_start |-> !w_sts.rem_busy)
        else $error("remainder unit restarted while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result overwrote a pending item");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("output valid without a result load");

endmodule
